// ===== rtl/mbe_pkg.sv =====
package mbe_pkg;

   // Data word width, step counter width, default fraction width and reset iteration limit.
   localparam int DATA_W         = 64;
   localparam int CNT_W          = 16;
   localparam int FRAC_BITS_DEF  = 51;
   localparam logic [CNT_W-1:0] MAX_ITER_RESET = 16'd18;

   // Operation codes for the serial multiplier.
   typedef enum logic [1:0] {
      MUL_AA = 2'd0,
      MUL_BB = 2'd1,
      MUL_AB = 2'd2
   } mul_op_type;

   // Saturating signed add of two data words.
   function automatic logic signed [DATA_W-1:0] sat_add(
      input logic signed [DATA_W-1:0] a,
      input logic signed [DATA_W-1:0] b
   );
      logic signed [DATA_W:0] s;
      begin
         s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
         if (s[DATA_W] != s[DATA_W-1]) begin
            sat_add = s[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
         end else begin
            sat_add = s[DATA_W-1:0];
         end
      end
   endfunction

   // Saturating signed subtract.
   function automatic logic signed [DATA_W-1:0] sat_sub(
      input logic signed [DATA_W-1:0] a,
      input logic signed [DATA_W-1:0] b
   );
      logic signed [DATA_W:0] s;
      begin
         s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
         if (s[DATA_W] != s[DATA_W-1]) begin
            sat_sub = s[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
         end else begin
            sat_sub = s[DATA_W-1:0];
         end
      end
   endfunction

endpackage

// ===== rtl/mandelbrot_escape_iteration.sv =====
// A tested step is five serial products plus update and test; an extra step after escape is
// three products plus update. An escaping point runs two extra steps before the strobe, a
// bounded one ends after max_iterations-1 tested steps, and a max_iterations of 0 or 1 goes
// from idle straight to the output state.
// One point at a time; busy drops with the strobe. Reset (synchronous, active high) returns
// to idle and restores max_iterations to 18. The result strobe lasts one cycle; no stall.
module mandelbrot_escape_iteration #(
   parameter int FRAC_BITS = mbe_pkg::FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic signed [mbe_pkg::DATA_W-1:0]  req_c_real,
   input  logic signed [mbe_pkg::DATA_W-1:0]  req_c_imag,
   input  logic                               csr_we,
   input  logic [mbe_pkg::CNT_W-1:0]          csr_wdata,
   output logic                               rsp_valid,
   output logic                               rsp_escaped,
   output logic [mbe_pkg::CNT_W-1:0]          rsp_steps,
   output logic signed [mbe_pkg::DATA_W-1:0]  rsp_z_real,
   output logic signed [mbe_pkg::DATA_W-1:0]  rsp_z_imag
);
   import mbe_pkg::*;

   localparam logic signed [DATA_W-1:0] FOUR = 64'sd4 <<< FRAC_BITS;

   typedef enum logic [2:0] {
      S_IDLE, S_MUL, S_WAIT, S_UPD, S_TEST, S_OUT
   } state_type;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     max_ff;
   logic signed [DATA_W-1:0] cr_ff, ci_ff, a_ff, b_ff, aa_ff, bb_ff, ab_ff;
   logic [CNT_W-1:0]     k_ff;
   logic [CNT_W-1:0]     budget;
   logic                 esc_ff;
   logic [1:0]           extra_ff;
   mul_op_type           op_ff;
   logic                 tphase_ff;
   logic                 rv_ff, re_ff;
   logic [CNT_W-1:0]     rs_ff;
   logic signed [DATA_W-1:0] rzr_ff, rzi_ff;

   logic                 m_start, m_done;
   logic signed [DATA_W-1:0] m_x, m_y, m_res;
   logic [5:0]           m_sh;
   logic signed [DATA_W-1:0] clr, cli, na, nb;

   assign budget = (max_ff == '0) ? 16'd1 : max_ff;

   // Clamp the request to plus or minus four.
   always_comb begin
      clr = (req_c_real > FOUR) ? FOUR : (req_c_real < -FOUR) ? -FOUR : req_c_real;
      cli = (req_c_imag > FOUR) ? FOUR : (req_c_imag < -FOUR) ? -FOUR : req_c_imag;
   end

   // Operand selection for the shared multiplier, and the saturated next z = z*z + c.
   always_comb begin
      m_x  = (op_ff == MUL_BB) ? b_ff : a_ff;
      m_y  = (op_ff == MUL_AA) ? a_ff : b_ff;
      m_sh = (op_ff == MUL_AB && !tphase_ff) ? 6'(FRAC_BITS-1) : 6'(FRAC_BITS);
      m_start = (state_ff == S_MUL);
      na = sat_add(sat_sub(aa_ff, bb_ff), cr_ff);
      nb = sat_add(ab_ff, ci_ff);
   end

   mbe_serial_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clock(clock), .reset(reset), .start(m_start), .op_x(m_x), .op_y(m_y),
      .shift(m_sh), .done(m_done), .result(m_res)
   );

   // Sequencer: three products per step, two more for the escape test.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (start) state_in = (budget == 16'd1) ? S_OUT : S_MUL;
         S_MUL:  state_in = S_WAIT;
         S_WAIT: if (m_done) begin
            if (tphase_ff) state_in = (op_ff == MUL_AA) ? S_MUL : S_TEST;
            else state_in = (op_ff == MUL_AB) ? S_UPD : S_MUL;
         end
         S_UPD:  state_in = S_MUL;
         S_TEST: state_in = S_MUL;
         S_OUT:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         max_ff   <= MAX_ITER_RESET;
         rv_ff    <= 1'b0;
      end else begin
         if (csr_we) max_ff <= csr_wdata;
         rv_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  cr_ff <= clr; ci_ff <= cli; a_ff <= clr; b_ff <= cli;
                  k_ff <= 16'd1; esc_ff <= 1'b0; extra_ff <= 2'd0;
                  op_ff <= MUL_AA; tphase_ff <= 1'b0;
               end
               state_ff <= state_in;
            end
            S_WAIT: begin
               if (m_done) begin
                  case (op_ff)
                     MUL_AA: begin aa_ff <= m_res; op_ff <= tphase_ff ? MUL_BB : MUL_BB; end
                     MUL_BB: begin bb_ff <= m_res; op_ff <= tphase_ff ? MUL_AA : MUL_AB; end
                     MUL_AB: ab_ff <= m_res;
                     default: op_ff <= MUL_AA;
                  endcase
                  if (tphase_ff && op_ff == MUL_AA) op_ff <= MUL_BB;
                  if (tphase_ff && op_ff == MUL_BB) op_ff <= MUL_AA;
               end
               state_ff <= state_in;
            end
            S_UPD: begin
               a_ff <= na; b_ff <= nb; op_ff <= MUL_AA;
               if (esc_ff) begin
                  tphase_ff <= 1'b0;
                  extra_ff  <= extra_ff + 2'd1;
                  if (extra_ff == 2'd1) state_ff <= S_OUT;
                  else state_ff <= S_MUL;
               end else begin
                  tphase_ff <= 1'b1;
                  state_ff  <= S_MUL;
               end
            end
            S_TEST: begin
               tphase_ff <= 1'b0;
               op_ff     <= MUL_AA;
               if (sat_add(aa_ff, bb_ff) > FOUR) begin
                  esc_ff   <= 1'b1;
                  state_ff <= S_MUL;
               end else if (k_ff + 16'd1 >= budget) begin
                  state_ff <= S_OUT;
               end else begin
                  k_ff     <= k_ff + 16'd1;
                  state_ff <= S_MUL;
               end
            end
            S_OUT: begin
               rv_ff  <= 1'b1;
               re_ff  <= esc_ff;
               rs_ff  <= esc_ff ? k_ff : '0;
               rzr_ff <= esc_ff ? a_ff : '0;
               rzi_ff <= esc_ff ? b_ff : '0;
               state_ff <= state_in;
            end
            default: state_ff <= state_in;
         endcase
      end
   end

   assign busy        = (state_ff != S_IDLE);
   assign rsp_valid   = rv_ff;
   assign rsp_escaped = re_ff;
   assign rsp_steps   = rs_ff;
   assign rsp_z_real  = rzr_ff;
   assign rsp_z_imag  = rzi_ff;

`ifndef NO_ASSERTIONS
   // A result follows the output state.
   a_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == S_OUT)) else $error("result without output state");
   // Non-escaped results carry zero steps.
   a_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_escaped) |-> rsp_steps == '0) else $error("steps nonzero");
   // Step count stays within the budget.
   a_k: assert property (@(posedge clock) disable iff (reset)
      busy |-> k_ff < budget || budget == 16'd1 || esc_ff) else $error("step overrun");
`endif

endmodule

// ===== rtl/mbe_serial_mul.sv =====
// Bit-serial signed multiplier on operand magnitudes, with floor shift and saturation.
// One multiplier bit per cycle; after the last shift-add step the finishing step (fin_ff)
// registers the floored, saturated result, and done is registered with it.
module mbe_serial_mul #(
   parameter int FRAC_BITS = mbe_pkg::FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [mbe_pkg::DATA_W-1:0]  op_x,
   input  logic signed [mbe_pkg::DATA_W-1:0]  op_y,
   input  logic [5:0]                         shift,
   output logic                               done,
   output logic signed [mbe_pkg::DATA_W-1:0]  result
);
   import mbe_pkg::*;

   localparam int PW = 2 * DATA_W;

   logic [DATA_W-1:0] mcand_ff, mcand_in;
   logic [DATA_W-1:0] mplier_ff, mplier_in;
   logic [PW-1:0]     acc_ff, acc_in;
   logic              neg_ff, neg_in;
   logic [5:0]        sh_ff, sh_in;
   logic [6:0]        cnt_ff, cnt_in;
   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [DATA_W-1:0] res_ff, res_in;

   logic [DATA_W-1:0] mag_x, mag_y;
   logic [PW-1:0]     q_full;
   logic              rem_nz, big;
   logic [DATA_W-1:0] q;
   logic [DATA_W:0]   qn;

   assign mag_x = op_x[DATA_W-1] ? (~op_x + 1'b1) : op_x;
   assign mag_y = op_y[DATA_W-1] ? (~op_y + 1'b1) : op_y;

   // Final floor and saturation from the full product.
   always_comb begin
      q_full = acc_ff >> sh_ff;
      q      = q_full[DATA_W-1:0];
      big    = |q_full[PW-1:DATA_W];
      rem_nz = |(acc_ff[DATA_W-1:0] & ((64'd1 << sh_ff) - 64'd1));
      qn     = {1'b0, q} + {{DATA_W{1'b0}}, rem_nz};
      res_in = res_ff;
      if (!neg_ff) begin
         if (big || q[DATA_W-1]) res_in = {1'b0, {(DATA_W-1){1'b1}}};
         else res_in = q;
      end else begin
         if (big || qn > {2'b01, {(DATA_W-1){1'b0}}}) res_in = {1'b1, {(DATA_W-1){1'b0}}};
         else res_in = ~qn[DATA_W-1:0] + 1'b1;
      end
   end

   // Shift-add step, one multiplier bit per cycle.
   always_comb begin
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;
      neg_in    = neg_ff;
      sh_in     = sh_ff;
      cnt_in    = cnt_ff;
      run_in    = run_ff;
      done_in   = 1'b0;
      if (start) begin
         mcand_in  = mag_x;
         mplier_in = mag_y;
         acc_in    = '0;
         neg_in    = op_x[DATA_W-1] ^ op_y[DATA_W-1];
         sh_in     = shift;
         cnt_in    = '0;
         run_in    = 1'b1;
      end else if (run_ff) begin
         acc_in    = (acc_ff >> 1) +
                     ({{DATA_W{1'b0}}, (mplier_ff[0] ? mcand_ff : {DATA_W{1'b0}})} << (DATA_W-1));
         mplier_in = mplier_ff >> 1;
         cnt_in    = cnt_ff + 7'd1;
         if (cnt_ff == 7'(DATA_W-1)) begin
            run_in = 1'b0;
         end
      end
   end

   logic fin_ff, fin_in;
   assign fin_in = run_ff && (cnt_ff == 7'(DATA_W-1));

   always_ff @(posedge clock) begin
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
      neg_ff    <= neg_in;
      sh_ff     <= sh_in;
      cnt_ff    <= cnt_in;
      if (fin_ff) res_ff <= res_in;
      if (reset) begin
         run_ff  <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         fin_ff  <= fin_in;
         done_ff <= fin_ff | done_in;
      end
   end

   assign done   = done_ff;
   assign result = res_ff;

`ifndef NO_ASSERTIONS
   // A product finishes only after a run.
   a_done_after_fin: assert property (@(posedge clock) disable iff (reset)
      done |-> $past(fin_ff)) else $error("done without finishing step");
   // The finishing step ends a run.
   a_fin_run: assert property (@(posedge clock) disable iff (reset)
      fin_ff |-> !run_ff || $past(start)) else $error("run still active at finish");
   // Counter stays in range.
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      run_ff |-> cnt_ff < 7'(DATA_W)) else $error("counter out of range");
   // Products are scaled by the fraction width or one less.
   a_shift: assert property (@(posedge clock) disable iff (reset)
      start |-> (shift == 6'(FRAC_BITS) || shift == 6'(FRAC_BITS-1)))
      else $error("unexpected product shift");
`endif

endmodule
